[rtl/core/vpfp_pkg.sv]
// voice prompt player package: payload structs, codes and fixed constants
// no dependencies; imported by every module of the player but vpfp_ram
package vpfp_pkg;

   // sizes fixed by the transaction fields
   localparam int CMD_W        = 2;
   localparam int ID_W         = 8;
   localparam int BYTE_W       = 8;
   localparam int ACTION_W     = 3;
   localparam int FLASH_ADDR_W = 24;
   localparam int HDR_CNT_W    = 3;

   // header layout: id, three address bytes, three length bytes, checksum
   localparam int HEADER_BYTES = 8;
   localparam int HDR_SHIFT    = 3;

   localparam logic [HDR_CNT_W-1:0] HDR_IDX_ID       = HDR_CNT_W'(0);
   localparam logic [HDR_CNT_W-1:0] HDR_IDX_ADDR_LO  = HDR_CNT_W'(1);
   localparam logic [HDR_CNT_W-1:0] HDR_IDX_ADDR_HI  = HDR_CNT_W'(3);
   localparam logic [HDR_CNT_W-1:0] HDR_IDX_LEN_LO   = HDR_CNT_W'(4);
   localparam logic [HDR_CNT_W-1:0] HDR_IDX_LEN_HI   = HDR_CNT_W'(6);
   localparam logic [HDR_CNT_W-1:0] HDR_IDX_LAST     = HDR_CNT_W'(HEADER_BYTES - 1);

   localparam logic [FLASH_ADDR_W-1:0] ALL_ONES24 = {FLASH_ADDR_W{1'b1}};
   localparam logic [ID_W-1:0]         NO_ID      = {ID_W{1'b1}};
   localparam logic [ID_W-1:0]         HIGHEST_ID_RESET = ID_W'(254);

   localparam int LIST_DEPTH_DEFAULT = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD     = 2'd0,
      CMD_PREPARE = 2'd1,
      CMD_FLASH   = 2'd2,
      CMD_DISMISS = 2'd3
   } command_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE         = 3'd0,
      ACT_END_READ     = 3'd1,
      ACT_HEADER_READ  = 3'd2,
      ACT_STREAM_START = 3'd3,
      ACT_BYTE_REQUEST = 3'd4,
      ACT_SAMPLE_OUT   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PENDING = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ID_W-1:0]   voice_id;
      logic [BYTE_W-1:0] flash_data;
      logic              buffer_ready;
   } req_type;

   typedef struct packed {
      logic [ACTION_W-1:0]     action;
      logic [FLASH_ADDR_W-1:0] flash_address;
      logic [BYTE_W-1:0]       sample_byte;
      logic                    list_empty;
      logic                    playing_done;
      logic                    list_overflow;
   } rsp_type;

endpackage

[rtl/core/vpfp_ram.sv]
// generic single write port ram with registered read
// no dependencies
module vpfp_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH      = 32,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/vpfp_seq.sv]
// playlist and header sequencer: state registers and per-transaction update
// depends on vpfp_pkg and vpfp_ram
module vpfp_seq
   import vpfp_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  req_type           req,
   input  logic              csr_wr_en,
   input  logic [ID_W-1:0]   csr_wr_data,
   output rsp_type           rsp
);

   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic [CW-1:0]           put_ff, put_in;
   logic [CW-1:0]           get_ff, get_in;
   logic [FLASH_ADDR_W-1:0] addr_ff, addr_in;
   logic [FLASH_ADDR_W-1:0] len_ff, len_in;
   logic [HDR_CNT_W-1:0]    hcnt_ff, hcnt_in;
   phase_type               phase_ff, phase_in;
   logic [ID_W-1:0]         hid_ff;
   logic                    byp_ff, byp_in;
   logic [ID_W-1:0]         byp_data_ff;

   logic            wr_en;
   logic [ID_W-1:0] ram_rd;
   logic [ID_W-1:0] head_id;
   logic            can_pop;
   logic            fetch;
   logic [FLASH_ADDR_W-1:0] a_tmp;
   logic [FLASH_ADDR_W-1:0] l_tmp;

   // playlist storage, read address follows the next get pointer
   vpfp_ram #(
      .WIDTH (ID_W),
      .DEPTH (LIST_DEPTH)
   ) u_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (put_ff[IW-1:0]),
      .wr_data (req.voice_id),
      .rd_addr (get_in[IW-1:0]),
      .rd_data (ram_rd)
   );

   // head of list, forwarding a write that hit the address being read
   assign head_id = byp_ff ? byp_data_ff : ram_rd;
   assign can_pop = (get_ff != put_ff) && (get_ff < DEPTH_C);
   assign wr_en   = accept && (command_type'(req.command) == CMD_ADD) && (put_ff < DEPTH_C);
   assign byp_in  = wr_en && (put_ff == get_in);

   // per-transaction state update and result
   always_comb begin
      put_in   = put_ff;
      get_in   = get_ff;
      addr_in  = addr_ff;
      len_in   = len_ff;
      hcnt_in  = hcnt_ff;
      phase_in = phase_ff;
      fetch    = 1'b0;
      a_tmp    = addr_ff;
      l_tmp    = len_ff;
      rsp      = '0;
      if (accept) begin
         unique case (command_type'(req.command))
            CMD_ADD: begin
               if (put_ff < DEPTH_C) begin
                  put_in = put_ff + ONE_C;
               end else begin
                  rsp.list_overflow = 1'b1;
               end
            end
            CMD_PREPARE: begin
               if (phase_ff == PH_IDLE) begin
                  priority if (len_ff == '0) begin
                     // nothing playing: pop the next prompt
                     if (can_pop) begin
                        get_in = get_ff + ONE_C;
                        fetch  = (head_id != NO_ID) && (head_id <= hid_ff);
                     end else begin
                        get_in = '0;
                        put_in = '0;
                     end
                     priority if (fetch) begin
                        rsp.action        = ACT_HEADER_READ;
                        rsp.flash_address = {{(FLASH_ADDR_W-ID_W-HDR_SHIFT){1'b0}},
                                             head_id, {HDR_SHIFT{1'b0}}};
                        hcnt_in           = '0;
                        phase_in          = PH_HEADER;
                     end else if (addr_ff != '0) begin
                        rsp.action        = ACT_STREAM_START;
                        rsp.flash_address = addr_ff;
                        addr_in           = '0;
                     end else begin
                        rsp.action = ACT_END_READ;
                     end
                  end else if (addr_ff != '0) begin
                     rsp.action        = ACT_STREAM_START;
                     rsp.flash_address = addr_ff;
                     addr_in           = '0;
                  end else if (req.buffer_ready) begin
                     rsp.action = ACT_BYTE_REQUEST;
                     phase_in   = PH_PENDING;
                  end else begin
                     // playing but the sample buffer is full
                     rsp.action = ACT_NONE;
                  end
               end
            end
            CMD_FLASH: begin
               unique case (phase_ff)
                  PH_HEADER: begin
                     // header byte: id, address, length, checksum
                     priority if (hcnt_ff == HDR_IDX_ID) begin
                        a_tmp = '0;
                        l_tmp = '0;
                     end else if (hcnt_ff >= HDR_IDX_ADDR_LO && hcnt_ff <= HDR_IDX_ADDR_HI) begin
                        a_tmp = {addr_ff[FLASH_ADDR_W-BYTE_W-1:0], req.flash_data};
                     end else if (hcnt_ff >= HDR_IDX_LEN_LO && hcnt_ff <= HDR_IDX_LEN_HI) begin
                        l_tmp = {len_ff[FLASH_ADDR_W-BYTE_W-1:0], req.flash_data};
                     end else begin
                        a_tmp = addr_ff;
                     end
                     if (hcnt_ff == HDR_IDX_LAST) begin
                        if (a_tmp == ALL_ONES24 || l_tmp == ALL_ONES24) begin
                           a_tmp = '0;
                           l_tmp = '0;
                        end
                        hcnt_in  = '0;
                        phase_in = PH_IDLE;
                     end else begin
                        hcnt_in = hcnt_ff + HDR_CNT_W'(1);
                     end
                     addr_in = a_tmp;
                     len_in  = l_tmp;
                  end
                  PH_PENDING: begin
                     rsp.action      = ACT_SAMPLE_OUT;
                     rsp.sample_byte = req.flash_data;
                     if (len_ff != '0) begin
                        len_in = len_ff - FLASH_ADDR_W'(1);
                     end
                     phase_in = PH_IDLE;
                  end
                  default: begin
                     // stray byte while idle is dropped
                     phase_in = phase_ff;
                  end
               endcase
            end
            CMD_DISMISS: begin
               put_in = '0;
               get_in = '0;
            end
            default: begin
               put_in = put_ff;
            end
         endcase
      end
      rsp.list_empty   = (put_in == '0) && (get_in == '0);
      rsp.playing_done = (len_in == '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         put_ff   <= '0;
         get_ff   <= '0;
         addr_ff  <= '0;
         len_ff   <= '0;
         hcnt_ff  <= '0;
         phase_ff <= PH_IDLE;
         hid_ff   <= HIGHEST_ID_RESET;
         byp_ff   <= 1'b0;
      end else begin
         put_ff   <= put_in;
         get_ff   <= get_in;
         addr_ff  <= addr_in;
         len_ff   <= len_in;
         hcnt_ff  <= hcnt_in;
         phase_ff <= phase_in;
         byp_ff   <= byp_in;
         if (csr_wr_en) begin
            hid_ff <= csr_wr_data;
         end
      end
   end

   // forwarded write data
   always_ff @(posedge clock) begin
      byp_data_ff <= req.voice_id;
   end

endmodule

[rtl/core/vpfp_out_buf.sv]
// result register with one skid entry for the response channel
// depends on vpfp_pkg
module vpfp_out_buf
   import vpfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_stall,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   assign out_free = !out_valid_ff || !out_stall;
   assign in_stall = skid_valid_ff;

   // refill the output register from the skid entry first
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

[rtl/core/voice_prompt_flash_player.sv]
// voice prompt player top level: sequencer plus response buffer
// depends on vpfp_pkg, vpfp_seq, vpfp_out_buf
//
// usage
//  - req channel (req_valid / req_stall / req_data) carries one command per
//    transaction: add id, prepare step, returned flash byte or dismiss list
//  - rsp channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
//    result per request transaction, in order
//  - csr_wr_en / csr_wr_data write the highest fetchable prompt id; write it
//    only while no request is outstanding
//  - each result is registered in the result register or the skid entry
//  - throughput: one request per cycle while req_stall is low; each
//    transaction is one sequencer pass from state to result register
//  - reset clears pointers, header state and flags and loads the id limit
//    with 254; the playlist memory is not cleared, only entries below the
//    put pointer are ever read
//  - when the receiver stalls, one further result is held in a skid entry
//    and req_stall then rises until the result register drains
module voice_prompt_flash_player
   import vpfp_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data,
   input  logic            csr_wr_en,
   input  logic [ID_W-1:0] csr_wr_data
);

   logic    accept;
   rsp_type seq_rsp;

   assign accept = req_valid && !req_stall;

   // sequencer
   vpfp_seq #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (seq_rsp)
   );

   // result register and skid entry
   vpfp_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (seq_rsp),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule
